/* src/nmbi_pkg.sv */
`timescale 1ns / 1ps

package nmbi_pkg;

  // Access kinds carried on the request channel
  localparam logic [2:0] KIND_CPU_RD = 3'd0;
  localparam logic [2:0] KIND_CPU_WR = 3'd1;
  localparam logic [2:0] KIND_PPU_RD = 3'd2;
  localparam logic [2:0] KIND_PPU_WR = 3'd3;
  localparam logic [2:0] KIND_TICK   = 3'd4;

  // Target memory codes on the result channel
  localparam logic [2:0] TGT_NONE = 3'd0;
  localparam logic [2:0] TGT_REG  = 3'd1;
  localparam logic [2:0] TGT_CODE = 3'd2;
  localparam logic [2:0] TGT_WRAM = 3'd3;
  localparam logic [2:0] TGT_PAT  = 3'd4;
  localparam logic [2:0] TGT_NT   = 3'd5;

  // Configuration register indexes
  localparam logic CFG_CODE_MASK = 1'b0;
  localparam logic CFG_PAT_MASK  = 1'b1;

  localparam int CODE_AW = 19;
  localparam int PAT_AW  = 18;

  // Bank register slots, address bits 14..11 of a CPU write at or above 0x8000
  localparam int          PAT_BANKS     = 12;
  localparam logic [3:0]  SLOT_CODE0    = 4'hc;
  localparam logic [3:0]  SLOT_CODE1_NT = 4'hd;
  localparam logic [3:0]  SLOT_CODE2    = 4'he;
  localparam logic [3:0]  SLOT_WRAM_EN  = 4'hf;

  localparam logic [14:0]        IRQ_TOP     = 15'h7fff;
  localparam logic [7:0]         NT_BANK_MIN = 8'he0;
  localparam logic [CODE_AW-1:0] CODE_PAGE   = 19'h02000;
  localparam logic [3:0]         NT_IDX_MASK = 4'hb;
  localparam logic [5:0]         PALETTE_HI  = 6'h3f;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] bus_address;
    logic [7:0]  write_value;
  } item_t;

  typedef struct packed {
    logic [2:0]         target;
    logic [CODE_AW-1:0] mem_address;
    logic               mem_write;
    logic [7:0]         read_value;
    logic               irq_line;
  } result_t;

endpackage

/* src/nmbi_req_if.sv */
`timescale 1ns / 1ps

interface nmbi_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] bus_address;
  logic [7:0]  write_value;

  modport source (output valid, output kind, output bus_address, output write_value,
                  input ready);
  modport sink (input valid, input kind, input bus_address, input write_value,
                output ready);
endinterface

/* src/nmbi_rsp_if.sv */
`timescale 1ns / 1ps

interface nmbi_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [18:0] mem_address;
  logic        mem_write;
  logic [7:0]  read_value;
  logic        irq_line;

  modport source (output valid, output target, output mem_address, output mem_write,
                  output read_value, output irq_line, input ready);
  modport sink (input valid, input target, input mem_address, input mem_write,
                input read_value, input irq_line, output ready);
endinterface

/* src/nmbi_core.sv */
`timescale 1ns / 1ps

module nmbi_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  nmbi_pkg::item_t                     item_i,
  input  logic [nmbi_pkg::CODE_AW-1:0]        code_mask_i,
  input  logic [nmbi_pkg::PAT_AW-1:0]         pat_mask_i,
  output nmbi_pkg::result_t                   result_o
);

  logic [7:0]  pat_bank_q  [nmbi_pkg::PAT_BANKS];
  logic [7:0]  pat_bank_d  [nmbi_pkg::PAT_BANKS];
  logic [5:0]  code_bank_q [3];
  logic [5:0]  code_bank_d [3];
  logic [3:0]  wram_en_q, wram_en_d;
  logic [1:0]  ciram_en_q, ciram_en_d;
  logic [14:0] irq_count_q, irq_count_d;
  logic        irq_armed_q, irq_armed_d;
  logic        irq_pending_q, irq_pending_d;

  logic [15:0]                  addr;
  logic [7:0]                   wval;
  logic                         is_wr;
  logic [3:0]                   slot;
  logic [nmbi_pkg::CODE_AW-1:0] code_base;
  logic [nmbi_pkg::CODE_AW-1:0] last_base;
  logic [3:0]                   pat_idx;
  logic [7:0]                   bank;
  logic                         to_nt;
  logic [14:0]                  count_inc;
  logic [nmbi_pkg::PAT_AW-1:0]  pat_addr;

  assign addr      = item_i.bus_address;
  assign wval      = item_i.write_value;
  assign is_wr     = (item_i.kind == nmbi_pkg::KIND_CPU_WR);
  assign slot      = addr[14:11];
  assign last_base = code_mask_i + 19'd1 - nmbi_pkg::CODE_PAGE;
  assign count_inc = irq_count_q + 15'd1;

  // Pick the code bank for the 8 KiB window, the top window is fixed to the last page
  always_comb begin
    case (addr[14:13])
      2'd0:    code_base = {code_bank_q[0], 13'd0};
      2'd1:    code_base = {code_bank_q[1], 13'd0};
      2'd2:    code_base = {code_bank_q[2], 13'd0};
      default: code_base = last_base;
    endcase
  end

  // Nametable space folds onto slots 8 to 11
  assign pat_idx  = addr[13] ? (addr[13:10] & nmbi_pkg::NT_IDX_MASK) : {1'b0, addr[12:10]};
  assign bank     = pat_bank_q[pat_idx];
  assign to_nt    = (bank >= nmbi_pkg::NT_BANK_MIN) && (addr[13] || ciram_en_q[addr[12]]);
  assign pat_addr = {bank, addr[9:0]} & pat_mask_i;

  // Decode the beat, build its result and the next state
  always_comb begin
    pat_bank_d    = pat_bank_q;
    code_bank_d   = code_bank_q;
    wram_en_d     = wram_en_q;
    ciram_en_d    = ciram_en_q;
    irq_count_d   = irq_count_q;
    irq_armed_d   = irq_armed_q;
    irq_pending_d = irq_pending_q;
    result_o      = '0;

    unique case (item_i.kind) inside
      nmbi_pkg::KIND_CPU_RD, nmbi_pkg::KIND_CPU_WR: begin
        if (addr[15:12] == 4'h5) begin
          if (is_wr) begin
            if (addr[11]) begin
              irq_count_d = {wval[6:0], irq_count_q[7:0]};
              irq_armed_d = wval[7];
            end else begin
              irq_count_d = {irq_count_q[14:8], wval};
            end
            irq_pending_d = 1'b0;
          end else begin
            result_o.target     = nmbi_pkg::TGT_REG;
            result_o.read_value = addr[11] ? {irq_armed_q, irq_count_q[14:8]}
                                           : irq_count_q[7:0];
          end
        end else if (addr[15:13] == 3'd3) begin
          result_o.target      = nmbi_pkg::TGT_WRAM;
          result_o.mem_address = {6'd0, addr[12:0]};
          result_o.mem_write   = is_wr && wram_en_q[addr[12:11]];
        end else if (addr[15]) begin
          if (is_wr) begin
            if (slot < 4'(nmbi_pkg::PAT_BANKS)) begin
              pat_bank_d[slot] = wval;
            end else begin
              unique case (slot)
                nmbi_pkg::SLOT_CODE0:    code_bank_d[0] = wval[5:0];
                nmbi_pkg::SLOT_CODE2:    code_bank_d[2] = wval[5:0];
                nmbi_pkg::SLOT_CODE1_NT: begin
                  code_bank_d[1] = wval[5:0];
                  ciram_en_d     = ~wval[7:6];
                end
                default:                 wram_en_d = ~wval[3:0];
              endcase
            end
          end else begin
            result_o.target      = nmbi_pkg::TGT_CODE;
            result_o.mem_address = ({6'd0, addr[12:0]} | code_base) & code_mask_i;
          end
        end
      end
      nmbi_pkg::KIND_PPU_RD, nmbi_pkg::KIND_PPU_WR: begin
        if (addr[13:8] != nmbi_pkg::PALETTE_HI) begin
          if (to_nt) begin
            result_o.target      = nmbi_pkg::TGT_NT;
            result_o.mem_address = {8'd0, bank[0], addr[9:0]};
            result_o.mem_write   = (item_i.kind == nmbi_pkg::KIND_PPU_WR);
          end else begin
            result_o.target      = nmbi_pkg::TGT_PAT;
            result_o.mem_address = {1'b0, pat_addr};
          end
        end
      end
      nmbi_pkg::KIND_TICK: begin
        // Advance while armed, stop at the top and raise the line there
        if (irq_armed_q && (irq_count_q != nmbi_pkg::IRQ_TOP)) begin
          irq_count_d = count_inc;
          if (count_inc == nmbi_pkg::IRQ_TOP) irq_pending_d = 1'b1;
        end
      end
      default: ;
    endcase

    result_o.irq_line = irq_pending_d;
  end

  // Hold the mapper state, update once per processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < nmbi_pkg::PAT_BANKS; i++) pat_bank_q[i] <= '0;
      for (int i = 0; i < 3; i++) code_bank_q[i] <= '0;
      wram_en_q     <= '0;
      ciram_en_q    <= '0;
      irq_count_q   <= '0;
      irq_armed_q   <= 1'b0;
      irq_pending_q <= 1'b0;
    end else if (step_i) begin
      pat_bank_q    <= pat_bank_d;
      code_bank_q   <= code_bank_d;
      wram_en_q     <= wram_en_d;
      ciram_en_q    <= ciram_en_d;
      irq_count_q   <= irq_count_d;
      irq_armed_q   <= irq_armed_d;
      irq_pending_q <= irq_pending_d;
    end
  end

endmodule

/* src/nes_mapper_bank_irq_unit.sv */
`timescale 1ns / 1ps

// Bank-switching and IRQ counter unit of a cartridge mapper. Each request beat is a CPU access,
// a PPU access or a counter tick; each gives exactly one result beat naming the target memory,
// the translated address, the write strobe, register read data and the IRQ line after the beat.
// The unit takes one beat per clock unless the result side stalls; each accepted beat sits in
// the input register, then passes the decode logic into the result register, which lets a new
// beat enter while a finished result waits. The user must write the two ROM size masks through
// the configuration port only while no beat is in flight; the unit does not enforce this.
module nes_mapper_bank_irq_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [nmbi_pkg::CODE_AW-1:0] cfg_data_i,
  nmbi_req_if.sink                     req_i,
  nmbi_rsp_if.source                   rsp_o
);

  logic [nmbi_pkg::CODE_AW-1:0] code_mask_q;
  logic [nmbi_pkg::PAT_AW-1:0]  pat_mask_q;

  logic               s1_valid_q;
  nmbi_pkg::item_t    s1_item_q;
  logic               s2_valid_q;
  nmbi_pkg::result_t  s2_res_q;
  nmbi_pkg::result_t  core_res;
  logic               s2_load;
  logic               s1_adv;
  logic               req_fire;

  // Handshake: the result register frees when empty or taken
  assign s2_load     = !s2_valid_q || rsp_o.ready;
  assign s1_adv      = s1_valid_q && s2_load;
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_fire    = req_i.valid && req_i.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_mask_q <= '1;
      pat_mask_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        nmbi_pkg::CFG_CODE_MASK: code_mask_q <= cfg_data_i;
        default:                 pat_mask_q  <= cfg_data_i[nmbi_pkg::PAT_AW-1:0];
      endcase
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (req_fire) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s2_load) s2_valid_q <= s1_valid_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_item_q.kind        <= req_i.kind;
      s1_item_q.bus_address <= req_i.bus_address;
      s1_item_q.write_value <= req_i.write_value;
    end
    if (s1_adv) s2_res_q <= core_res;
  end

  nmbi_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_adv),
    .item_i      (s1_item_q),
    .code_mask_i (code_mask_q),
    .pat_mask_i  (pat_mask_q),
    .result_o    (core_res)
  );

  assign rsp_o.valid       = s2_valid_q;
  assign rsp_o.target      = s2_res_q.target;
  assign rsp_o.mem_address = s2_res_q.mem_address;
  assign rsp_o.mem_write   = s2_res_q.mem_write;
  assign rsp_o.read_value  = s2_res_q.read_value;
  assign rsp_o.irq_line    = s2_res_q.irq_line;

endmodule

/* src/nmbi_checker.sv */
`timescale 1ns / 1ps

module nmbi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  target_i,
  input logic [18:0] mem_address_i,
  input logic        mem_write_i,
  input logic [7:0]  read_value_i
);

  // A stalled result beat holds its target and address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(target_i) && $stable(mem_address_i))
    else $error("stalled result beat changed");

  // Only work RAM and nametable RAM are ever written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && mem_write_i |->
      (target_i == nmbi_pkg::TGT_WRAM) || (target_i == nmbi_pkg::TGT_NT))
    else $error("write strobe on a read-only target");

  // Register data appears only on register reads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (target_i != nmbi_pkg::TGT_REG) |-> read_value_i == 8'd0)
    else $error("read data outside a register read");

  // Nametable addresses stay within two 1 KiB pages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (target_i == nmbi_pkg::TGT_NT) |-> mem_address_i[18:11] == 8'd0)
    else $error("nametable address out of range");

endmodule

bind nes_mapper_bank_irq_unit nmbi_checker u_nmbi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .target_i      (rsp_o.target),
  .mem_address_i (rsp_o.mem_address),
  .mem_write_i   (rsp_o.mem_write),
  .read_value_i  (rsp_o.read_value)
);

/* sim/nmbi_access_checker.sv */
`timescale 1ns / 1ps

module nmbi_access_checker
  import nmbi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [CODE_AW-1:0] cfg_data_i,
  nmbi_req_if                req_i,
  nmbi_rsp_if                rsp_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  // Shadow copy of the mapper state and the two size masks
  logic [7:0]         pat_bank [PAT_BANKS];
  logic [5:0]         code_bank [3];
  logic [3:0]         wram_wen;
  logic [1:0]         nt_en;
  logic [14:0]        irq_count;
  logic               irq_armed;
  logic               irq_pending;
  logic [CODE_AW-1:0] code_mask;
  logic [PAT_AW-1:0]  pat_mask;

  result_t due_results [$];
  int      mismatches;

  // Translate one access and advance the shadow state
  function automatic result_t map_access(item_t it);
    result_t            r;
    logic [15:0]        a;
    logic [13:0]        p;
    logic [7:0]         v;
    logic [7:0]         bank;
    logic [3:0]         slot;
    logic [CODE_AW-1:0] base;
    logic               to_nt;
    logic               wr;
    r    = '0;
    a    = it.bus_address;
    v    = it.write_value;
    p    = a[13:0];
    slot = a[14:11];
    wr   = (it.kind == KIND_CPU_WR);
    case (it.kind)
      KIND_CPU_RD, KIND_CPU_WR: begin
        if (a >= 16'h5000 && a < 16'h6000) begin
          // IRQ counter: bit 11 picks the high half
          if (wr) begin
            if (a[11]) begin
              irq_count[14:8] = v[6:0];
              irq_armed       = v[7];
            end else begin
              irq_count[7:0] = v;
            end
            irq_pending = 1'b0;
          end else begin
            r.target     = TGT_REG;
            r.read_value = a[11] ? {irq_armed, irq_count[14:8]} : irq_count[7:0];
          end
        end else if (a >= 16'h6000 && a < 16'h8000) begin
          r.target      = TGT_WRAM;
          r.mem_address = {6'd0, a[12:0]};
          if (wr) r.mem_write = wram_wen[a[12:11]];
        end else if (a[15]) begin
          if (wr) begin
            case (slot)
              SLOT_CODE0: code_bank[0] = v[5:0];
              SLOT_CODE2: code_bank[2] = v[5:0];
              SLOT_CODE1_NT: begin
                code_bank[1] = v[5:0];
                nt_en[0]     = ~v[6];
                nt_en[1]     = ~v[7];
              end
              SLOT_WRAM_EN: wram_wen = ~v[3:0];
              default: pat_bank[slot] = v;
            endcase
          end else begin
            // Top window is pinned to the last 8 KiB page of the code ROM
            if (a[14:13] == 2'd3) base = code_mask + 19'd1 - CODE_PAGE;
            else base = {code_bank[a[14:13]], 13'd0};
            r.target      = TGT_CODE;
            r.mem_address = ({6'd0, a[12:0]} | base) & code_mask;
          end
        end
      end
      KIND_PPU_RD, KIND_PPU_WR: begin
        if (p[13:8] != PALETTE_HI) begin
          if (!p[13]) begin
            bank  = pat_bank[{1'b0, p[12:10]}];
            to_nt = (bank >= NT_BANK_MIN) && nt_en[p[12]];
          end else begin
            bank  = pat_bank[p[13:10] & NT_IDX_MASK];
            to_nt = (bank >= NT_BANK_MIN);
          end
          if (to_nt) begin
            r.target      = TGT_NT;
            r.mem_address = {8'd0, bank[0], p[9:0]};
            r.mem_write   = (it.kind == KIND_PPU_WR);
          end else begin
            r.target      = TGT_PAT;
            r.mem_address = {1'b0, {bank, p[9:0]} & pat_mask};
          end
        end
      end
      KIND_TICK: begin
        if (irq_armed && irq_count != IRQ_TOP) begin
          irq_count = irq_count + 15'd1;
          if (irq_count == IRQ_TOP) irq_pending = 1'b1;
        end
      end
      default: ;
    endcase
    r.irq_line = irq_pending;
    return r;
  endfunction

  function automatic int count_mismatch(string field, logic [18:0] want, logic [18:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Watch both channels: compare the result beat first, then queue the new access
  always @(posedge clk_i or negedge rst_ni) begin
    item_t   beat;
    result_t want;
    int      bad;
    if (!rst_ni) begin
      for (int i = 0; i < PAT_BANKS; i++) pat_bank[i] = '0;
      for (int i = 0; i < 3; i++) code_bank[i] = '0;
      wram_wen     = '0;
      nt_en        = '0;
      irq_count    = '0;
      irq_armed    = 1'b0;
      irq_pending  = 1'b0;
      code_mask    = '1;
      pat_mask     = '1;
      mismatches   = 0;
      due_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      bad = 0;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_CODE_MASK) code_mask = cfg_data_i;
        else pat_mask = cfg_data_i[PAT_AW-1:0];
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (due_results.size() == 0) begin
          $error("result beat with no access outstanding");
          bad = 1;
        end else begin
          want = due_results.pop_front();
          bad += count_mismatch("target", want.target, rsp_i.target);
          bad += count_mismatch("mem_address", want.mem_address, rsp_i.mem_address);
          bad += count_mismatch("mem_write", want.mem_write, rsp_i.mem_write);
          bad += count_mismatch("read_value", want.read_value, rsp_i.read_value);
          bad += count_mismatch("irq_line", want.irq_line, rsp_i.irq_line);
        end
      end
      if (req_i.valid && req_i.ready) begin
        beat.kind        = req_i.kind;
        beat.bus_address = req_i.bus_address;
        beat.write_value = req_i.write_value;
        due_results.push_back(map_access(beat));
      end
      mismatches   = mismatches + bad;
      fail_count_o <= mismatches;
      pending_o    <= due_results.size();
    end
  end

endmodule

/* sim/tb_nes_mapper_bank_irq_unit.sv */
`timescale 1ns / 1ps

module tb_nes_mapper_bank_irq_unit;
  import nmbi_pkg::*;

  localparam int LONG_HOLD    = 60;
  localparam int PHASES       = 6;
  localparam int PHASE_ACCESS = 270;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we;
  logic               cfg_index;
  logic [CODE_AW-1:0] cfg_data;

  int fail_count;
  int pending;
  int send_idle_pct = 7;
  int recv_idle_pct = 85;
  bit hold_req      = 1'b0;

  nmbi_req_if req_bus ();
  nmbi_rsp_if rsp_bus ();

  nes_mapper_bank_irq_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  nmbi_access_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .req_i        (req_bus),
    .rsp_i        (rsp_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int  hold_left;
    bit  hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one beat after a random gap; valid stays high once the beat is taken
  task automatic send_beat(input logic [2:0] kind, input logic [15:0] addr,
                           input logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.kind        <= kind;
    req_bus.bus_address <= addr;
    req_bus.write_value <= val;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_masks(input logic [CODE_AW-1:0] code_m, input logic [PAT_AW-1:0] pat_m);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CODE_MASK;
    cfg_data  <= code_m;
    @(posedge clk_i);
    cfg_index <= CFG_PAT_MASK;
    cfg_data  <= {1'b0, pat_m};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Mostly decodable accesses, weighted towards the register windows
  function automatic item_t pick_access();
    item_t it;
    int    roll;
    int    zone;
    roll           = $urandom_range(99);
    zone           = $urandom_range(9);
    it.bus_address = 16'($urandom);
    it.write_value = 8'($urandom_range(255));
    if (roll < 22) it.kind = KIND_CPU_RD;
    else if (roll < 47) it.kind = KIND_CPU_WR;
    else if (roll < 65) it.kind = KIND_PPU_RD;
    else if (roll < 77) it.kind = KIND_PPU_WR;
    else if (roll < 95) it.kind = KIND_TICK;
    else it.kind = 3'(KIND_TICK + 1 + $urandom_range(2));
    if (it.kind == KIND_CPU_RD || it.kind == KIND_CPU_WR) begin
      if (zone < 2) it.bus_address = 16'h5000 + 16'($urandom_range(16'h0fff));
      else if (zone < 4) it.bus_address = 16'h6000 + 16'($urandom_range(16'h1fff));
      else if (zone < 9) it.bus_address = 16'h8000 + 16'($urandom_range(16'h7fff));
    end
    if (it.kind == KIND_CPU_WR) begin
      // Push bank values into the nametable range and arm the counter often
      if ($urandom_range(1)) it.write_value |= NT_BANK_MIN;
      if (it.bus_address[15:12] == 4'h5 && $urandom_range(3) == 0) it.write_value = 8'hff;
    end
    return it;
  endfunction

  initial begin
    item_t it;
    int    code_k;
    int    pat_k;
    req_bus.valid       <= 1'b0;
    req_bus.kind        <= KIND_CPU_RD;
    req_bus.bus_address <= '0;
    req_bus.write_value <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_CODE_MASK;
    cfg_data            <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Counter: arm near the top, saturate, then clear the request
    send_beat(KIND_CPU_RD, 16'h5000, 8'h00);
    send_beat(KIND_CPU_WR, 16'h5800, 8'hff);
    send_beat(KIND_CPU_WR, 16'h5000, 8'hfd);
    send_beat(KIND_CPU_RD, 16'h5fff, 8'h00);
    send_beat(KIND_TICK,   16'h0000, 8'h00);
    send_beat(KIND_TICK,   16'hffff, 8'hff);
    send_beat(KIND_TICK,   16'h0000, 8'h00);
    send_beat(KIND_CPU_RD, 16'h57ff, 8'h00);
    send_beat(KIND_CPU_WR, 16'h5000, 8'h00);
    // Work RAM enables: quarters one and three open
    send_beat(KIND_CPU_WR, 16'hf800, 8'h05);
    send_beat(KIND_CPU_WR, 16'h6000, 8'haa);
    send_beat(KIND_CPU_WR, 16'h6800, 8'h55);
    send_beat(KIND_CPU_RD, 16'h7fff, 8'h00);
    // Bank registers, nametable enables and code pages
    send_beat(KIND_CPU_WR, 16'h8000, 8'he1);
    send_beat(KIND_CPU_WR, 16'he800, 8'h3f);
    send_beat(KIND_CPU_WR, 16'he000, 8'hff);
    send_beat(KIND_CPU_WR, 16'hf000, 8'h01);
    send_beat(KIND_CPU_WR, 16'hd800, 8'he0);
    // PPU: nametable via enabled half, name table window, palette, plain pattern
    send_beat(KIND_PPU_RD, 16'h0000, 8'h00);
    send_beat(KIND_PPU_WR, 16'h03ff, 8'hff);
    send_beat(KIND_PPU_WR, 16'h2c00, 8'h00);
    send_beat(KIND_PPU_RD, 16'hffff, 8'h00);
    send_beat(KIND_PPU_WR, 16'h1400, 8'h00);
    // Code windows, the fixed last page and undecoded space
    send_beat(KIND_CPU_RD, 16'ha000, 8'h00);
    send_beat(KIND_CPU_RD, 16'hffff, 8'h00);
    send_beat(KIND_CPU_RD, 16'h0000, 8'h00);
    send_beat(3'(KIND_TICK + 3), 16'h5800, 8'hff);

    // Random phases, each under its own masks; each pair of phases shares an idling pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin code_k = CODE_AW; pat_k = PAT_AW; end
        1: begin code_k = 13;      pat_k = 10;     end
        3: begin code_k = 13;      pat_k = PAT_AW; end
        4: begin code_k = CODE_AW; pat_k = 10;     end
        default: begin
          code_k = $urandom_range(CODE_AW, 13);
          pat_k  = $urandom_range(PAT_AW, 10);
        end
      endcase
      set_masks(CODE_AW'((1 << code_k) - 1), PAT_AW'((1 << pat_k) - 1));
      case (ph / 2)
        0: begin send_idle_pct <= 7;  recv_idle_pct <= 85; end
        1: begin send_idle_pct <= 85; recv_idle_pct <= 7;  end
        default: begin send_idle_pct <= 0; recv_idle_pct <= 0; end
      endcase
      for (int n = 0; n < PHASE_ACCESS; n++) begin
        if (n == 100) hold_req <= ~hold_req;
        if (n == 200 && ph[0]) drain_results();
        it = pick_access();
        send_beat(it.kind, it.bus_address, it.write_value);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
